// ===== src/pri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pri_pkg
// Shared types, codes and arithmetic helpers of the pedigree relationship
// inverse block.
// ----------------------------------------------------------------------------
package pri_pkg;

    localparam int          Q_FRAC = 28;
    localparam logic [39:0] Q_HI   = 40'h7F_FFFF_FFFF;
    localparam logic [40:0] Q_ONE  = 41'h00_1000_0000;
    localparam int          VW     = 29;  // path term width, never above 1.0

    localparam logic [1:0] REQ_LOAD     = 2'd0;
    localparam logic [1:0] REQ_COMPUTE  = 2'd1;
    localparam logic [1:0] REQ_RD_DIAG  = 2'd2;
    localparam logic [1:0] REQ_RD_ENTRY = 2'd3;

    typedef logic [4:0] t_op;

    localparam t_op OP_IDLE   = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_RDISS  = 5'd2;
    localparam t_op OP_RDOUT  = 5'd3;
    localparam t_op OP_CINIT  = 5'd4;
    localparam t_op OP_STEP   = 5'd5;
    localparam t_op OP_PAR    = 5'd6;
    localparam t_op OP_US     = 5'd7;
    localparam t_op OP_UD     = 5'd8;
    localparam t_op OP_DEN    = 5'd9;
    localparam t_op OP_CHK    = 5'd10;
    localparam t_op OP_ITER   = 5'd11;
    localparam t_op OP_WRI    = 5'd12;
    localparam t_op OP_PS_RD  = 5'd13;
    localparam t_op OP_PS_WR  = 5'd14;
    localparam t_op OP_PD_RD  = 5'd15;
    localparam t_op OP_PD_WR  = 5'd16;
    localparam t_op OP_PAIR   = 5'd17;
    localparam t_op OP_JCHK   = 5'd18;
    localparam t_op OP_JPAR   = 5'd19;
    localparam t_op OP_JVS    = 5'd20;
    localparam t_op OP_JVD    = 5'd21;
    localparam t_op OP_JSUM   = 5'd22;
    localparam t_op OP_JMUL   = 5'd23;
    localparam t_op OP_JWR    = 5'd24;
    localparam t_op OP_CDONE  = 5'd25;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_dp_cmd;

    typedef struct packed {
        logic i_end;
        logic j_end;
        logic stop;
        logic iter_done;
    } t_dp_stat;

    // saturating clamp of a non-negative sum
    function automatic logic [39:0] sat40(input logic [40:0] v);
        sat40 = (v > {1'b0, Q_HI}) ? Q_HI : v[39:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/pedigree_relationship_inverse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pedigree_relationship_inverse
// Sparse inverse numerator relationship matrix with inbreeding (Quaas).
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A load passes through the
// load state and a read through its issue and output states before its
// result is valid; the next request transfers in the cycle its predecessor's
// result does. A compute runs a pass for each loaded animal, set by the
// bit-serial reciprocal (57 steps), and within that pass a chain of term
// memory reads for each later animal. No clearing pass is needed after
// reset or before a compute. Values are signed Q12.28.
// ----------------------------------------------------------------------------
module pedigree_relationship_inverse
    import pri_pkg::*;
#(
    parameter int MAX_ANIMALS = 1024,
    parameter int MAX_ENTRIES = 3072
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_req_type,
    input  wire logic [10:0]  i_sire_id,
    input  wire logic [10:0]  i_dam_id,
    input  wire logic [11:0]  i_read_index,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [10:0]       o_row_index,
    output logic [10:0]       o_col_index,
    output logic [39:0]       o_coef_value,
    output logic [11:0]       o_entry_count,
    output logic              o_error_flag
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pri_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    pri_dpath #(
        .MAX_ANIMALS (MAX_ANIMALS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_sire_id     (i_sire_id),
        .i_dam_id      (i_dam_id),
        .i_read_index  (i_read_index),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_coef_value  (o_coef_value),
        .o_entry_count (o_entry_count),
        .o_error_flag  (o_error_flag)
    );

endmodule
`default_nettype wire

// ===== src/pri_rootdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pri_rootdiv
// Bit-serial reciprocal 2^56/den (saturated) and square root of den<<28,
// both started together; one quotient bit and one root bit per cycle.
// ----------------------------------------------------------------------------
module pri_rootdiv
    import pri_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [28:0]   i_den,
    output logic               o_done,
    output logic [39:0]        o_rden,
    output logic [VW-1:0]      o_root
);

    localparam int DIV_STEPS = 57;

    logic [28:0] r_rem;
    logic [56:0] r_quo;
    logic [5:0]  r_dcnt;
    logic [57:0] r_x, r_r, r_bit;

    logic [29:0] rem_sh;
    logic        ge;
    logic [57:0] trial;

    assign rem_sh = {r_rem, (r_dcnt == 6'(DIV_STEPS))};
    assign ge     = rem_sh >= {1'b0, i_den};
    assign trial  = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_bit  <= '0;
        end else if (i_start) begin
            r_dcnt <= 6'(DIV_STEPS);
            r_bit  <= 58'(1) << 56;
        end else begin
            if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 6'd1;
            end
            if (r_bit != '0) begin
                r_bit <= r_bit >> 2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= '0;
            r_x   <= 58'(i_den) << Q_FRAC;
            r_r   <= '0;
        end else begin
            if (r_dcnt != '0) begin
                r_rem <= ge ? 29'(rem_sh - {1'b0, i_den}) : rem_sh[28:0];
                r_quo <= {r_quo[55:0], ge};
            end
            if (r_bit != '0) begin
                if (r_x >= trial) begin
                    r_x <= r_x - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
            end
        end
    end

    assign o_done = (r_dcnt == '0) && (r_bit == '0);
    assign o_rden = (|r_quo[56:39]) ? Q_HI : r_quo[39:0];
    assign o_root = r_r[VW-1:0];

endmodule
`default_nettype wire

// ===== src/pri_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pri_ctrl
// Request sequencer: handshakes, result valid, and the compute walk order.
// ----------------------------------------------------------------------------
module pri_ctrl
    import pri_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [1:0]  i_req_type,
    input  wire logic        i_out_ready,
    input  wire t_dp_stat    i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_dp_cmd          o_cmd
);

    t_op  r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign o_in_ready  = (r_state == OP_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_cmd.op     = r_state;
    assign o_cmd.accept = accept;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            OP_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_LOAD:    n_state = OP_LOAD;
                        REQ_COMPUTE: n_state = OP_CINIT;
                        default:     n_state = OP_RDISS;
                    endcase
                end
            end
            OP_LOAD: begin
                n_state     = OP_IDLE;
                n_out_valid = 1'b1;
            end
            OP_RDISS: n_state = OP_RDOUT;
            OP_RDOUT: begin
                n_state     = OP_IDLE;
                n_out_valid = 1'b1;
            end
            OP_CINIT: n_state = OP_STEP;
            OP_STEP:  n_state = i_stat.i_end ? OP_CDONE : OP_PAR;
            OP_PAR:   n_state = OP_US;
            OP_US:    n_state = OP_UD;
            OP_UD:    n_state = OP_DEN;
            OP_DEN:   n_state = OP_CHK;
            OP_CHK:   n_state = i_stat.stop ? OP_CDONE : OP_ITER;
            OP_ITER:  n_state = i_stat.iter_done ? OP_WRI : OP_ITER;
            OP_WRI:   n_state = OP_PS_RD;
            OP_PS_RD: n_state = OP_PS_WR;
            OP_PS_WR: n_state = OP_PD_RD;
            OP_PD_RD: n_state = OP_PD_WR;
            OP_PD_WR: n_state = OP_PAIR;
            OP_PAIR:  n_state = OP_JCHK;
            OP_JCHK:  n_state = i_stat.j_end ? OP_STEP : OP_JPAR;
            OP_JPAR:  n_state = OP_JVS;
            OP_JVS:   n_state = OP_JVD;
            OP_JVD:   n_state = OP_JSUM;
            OP_JSUM:  n_state = OP_JMUL;
            OP_JMUL:  n_state = OP_JWR;
            OP_JWR:   n_state = OP_JCHK;
            OP_CDONE: begin
                n_state     = OP_IDLE;
                n_out_valid = 1'b1;
            end
            default:  n_state = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= OP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== src/pri_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pri_dpath
// Pedigree, per-animal term and entry memories, walk registers and the
// result register.
// ----------------------------------------------------------------------------
module pri_dpath
    import pri_pkg::*;
#(
    parameter int MAX_ANIMALS = 1024,
    parameter int MAX_ENTRIES = 3072
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_dp_cmd      i_cmd,
    output t_dp_stat          o_stat,
    input  wire logic [1:0]   i_req_type,
    input  wire logic [10:0]  i_sire_id,
    input  wire logic [10:0]  i_dam_id,
    input  wire logic [11:0]  i_read_index,
    output logic [10:0]       o_row_index,
    output logic [10:0]       o_col_index,
    output logic [39:0]       o_coef_value,
    output logic [11:0]       o_entry_count,
    output logic              o_error_flag
);

    localparam int AW  = $clog2(MAX_ANIMALS);
    localparam int CW  = $clog2(MAX_ANIMALS + 1);
    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int ECW = $clog2(MAX_ENTRIES + 1);
    localparam int MW  = (CW > ECW) ? CW : ECW;
    localparam int XW  = ((MW > 12) ? MW : 12) + 1;
    localparam int NW  = ECW + 1;
    localparam int EDW = 2 * AW + 40;

    // captured request
    logic [1:0]  r_req;
    logic [10:0] r_sire_in, r_dam_in;
    logic [11:0] r_idx;

    logic [CW-1:0]  r_loaded, r_done_n;
    logic [ECW-1:0] r_etotal;
    logic           r_walk_err;

    logic [CW-1:0]   r_i, r_j, r_s, r_d, r_js, r_jd;
    logic [39:0]     r_us, r_ud, r_ui, r_uj;
    logic [40:0]     r_den;
    logic [VW-1:0]   r_vs, r_vd, r_summ;
    logic [2*VW-1:0] r_prod;

    logic [10:0] r_row, r_col;
    logic [39:0] r_coef;
    logic        r_err;

    // memories
    logic [2*CW-1:0] par_mem [MAX_ANIMALS];
    logic [39:0]     u_mem   [MAX_ANIMALS];
    logic [VW-1:0]   v_mem   [MAX_ANIMALS];
    logic [39:0]     d_mem   [MAX_ANIMALS];
    logic [EDW-1:0]  ent_mem [MAX_ENTRIES];

    logic [2*CW-1:0] par_rd, par_wdata;
    logic [AW-1:0]   par_raddr, par_waddr;
    logic            par_we;
    logic [39:0]     u_rd, u_wdata;
    logic [AW-1:0]   u_raddr, u_waddr;
    logic            u_we;
    logic [VW-1:0]   v_rd, v_wdata;
    logic [AW-1:0]   v_raddr, v_waddr;
    logic            v_we;
    logic [39:0]     d_rd, d_wdata;
    logic [AW-1:0]   d_raddr, d_waddr;
    logic            d_we;
    logic [EDW-1:0]  ent_rd, ent_wdata;
    logic            ent_we;

    logic [CW-1:0] par_rd_s, par_rd_d;
    logic [XW-1:0] me;
    logic          ld_full, sire_ok, dam_ok;
    logic          diag_ok, diag_fresh, ent_ok;
    logic [1:0]    need;
    logic          ent_full, den_bad;
    logic [40:0]   den_w;
    logic [39:0]   rden, r25, r50, pair_coef, u_add_i, u_add_j, d_add;
    logic [VW-1:0] root, summ_n;
    logic [CW-1:0] hi, lo;
    logic          js_live, jd_live, iter_done;
    logic [AW-1:0] ent_row_rd, ent_col_rd;

    assign par_rd_s = par_rd[2*CW-1:CW];
    assign par_rd_d = par_rd[CW-1:0];

    assign me         = XW'(r_loaded) + XW'(1);
    assign ld_full    = XW'(r_loaded) >= XW'(MAX_ANIMALS);
    assign sire_ok    = XW'(r_sire_in) < me;
    assign dam_ok     = XW'(r_dam_in) < me;
    assign diag_ok    = XW'(r_idx) < XW'(r_loaded);
    assign diag_fresh = XW'(r_idx) < XW'(r_done_n);
    assign ent_ok     = XW'(r_idx) < XW'(r_etotal);

    assign need     = (r_s != '0 && r_d != '0) ? 2'd3 :
                      ((r_s != '0 || r_d != '0) ? 2'd1 : 2'd0);
    assign ent_full = (NW'(r_etotal) + NW'(need)) > NW'(MAX_ENTRIES);
    assign den_w    = Q_ONE - 41'(r_us >> 2) - 41'(r_ud >> 2);
    assign den_bad  = r_den[40] || (r_den == '0);

    assign r25       = {2'b00, rden[39:2]};
    assign r50       = 40'd0 - {1'b0, rden[39:1]};
    assign hi        = (r_s > r_d) ? r_s : r_d;
    assign lo        = (r_s > r_d) ? r_d : r_s;
    assign pair_coef = (r_s == r_d) ? {r25[38:0], 1'b0} : r25;

    // only parents at or past the current animal carry a path term
    assign js_live = (r_js != '0) && (r_js > r_i);
    assign jd_live = (r_jd != '0) && (r_jd > r_i);
    assign summ_n  = VW'((r_vs >> 1) + (r_vd >> 1));
    assign u_add_i = sat40(41'(r_ui) + r_den);
    assign u_add_j = sat40(41'(r_uj) + 41'(r_prod[2*VW-1:Q_FRAC]));
    assign d_add   = sat40(41'(d_rd) + 41'(r25));

    assign ent_row_rd = ent_rd[EDW-1:AW+40];
    assign ent_col_rd = ent_rd[AW+39:40];

    pri_rootdiv u_rootdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_CHK),
        .i_den   (r_den[28:0]),
        .o_done  (iter_done),
        .o_rden  (rden),
        .o_root  (root)
    );

    assign o_stat.i_end     = r_i >= r_loaded;
    assign o_stat.j_end     = r_j >= r_loaded;
    assign o_stat.stop      = den_bad || ent_full;
    assign o_stat.iter_done = iter_done;

    // memory port steering
    always_comb begin
        par_we    = (i_cmd.op == OP_LOAD) && !ld_full;
        par_waddr = AW'(r_loaded);
        par_wdata = {(sire_ok ? CW'(r_sire_in) : CW'(0)), (dam_ok ? CW'(r_dam_in) : CW'(0))};
        par_raddr = (i_cmd.op == OP_JCHK) ? AW'(r_j) : AW'(r_i);

        u_raddr = AW'(r_i);
        u_we    = 1'b0;
        u_waddr = AW'(r_i);
        u_wdata = u_add_i;
        v_raddr = AW'(r_jd - CW'(1));
        v_we    = 1'b0;
        v_waddr = AW'(r_i);
        v_wdata = root;
        d_raddr = AW'(r_idx);
        d_we    = 1'b0;
        d_waddr = AW'(r_i);
        d_wdata = rden;
        ent_we    = 1'b0;
        ent_wdata = {AW'(r_i), AW'(r_s - CW'(1)), r50};
        case (i_cmd.op)
            OP_PAR:  u_raddr = AW'(par_rd_s - CW'(1));
            OP_US:   u_raddr = AW'(r_d - CW'(1));
            OP_JVD:  u_raddr = AW'(r_j);
            OP_JPAR: v_raddr = AW'(par_rd_s - CW'(1));
            OP_WRI: begin
                u_we = 1'b1;
                v_we = 1'b1;
                d_we = 1'b1;
            end
            OP_PS_RD: begin
                d_raddr = AW'(r_s - CW'(1));
                ent_we  = (r_s != '0);
            end
            OP_PS_WR: begin
                d_we    = (r_s != '0);
                d_waddr = AW'(r_s - CW'(1));
                d_wdata = d_add;
            end
            OP_PD_RD: begin
                d_raddr   = AW'(r_d - CW'(1));
                ent_we    = (r_d != '0);
                ent_wdata = {AW'(r_i), AW'(r_d - CW'(1)), r50};
            end
            OP_PD_WR: begin
                d_we    = (r_d != '0);
                d_waddr = AW'(r_d - CW'(1));
                d_wdata = d_add;
            end
            OP_PAIR: begin
                ent_we    = (r_s != '0) && (r_d != '0);
                ent_wdata = {AW'(hi - CW'(1)), AW'(lo - CW'(1)), pair_coef};
            end
            OP_JWR: begin
                u_we    = 1'b1;
                u_waddr = AW'(r_j);
                u_wdata = u_add_j;
                v_we    = 1'b1;
                v_waddr = AW'(r_j);
                v_wdata = r_summ;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rd <= par_mem[par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            u_mem[u_waddr] <= u_wdata;
        end
        u_rd <= u_mem[u_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            v_mem[v_waddr] <= v_wdata;
        end
        v_rd <= v_mem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            d_mem[d_waddr] <= d_wdata;
        end
        d_rd <= d_mem[d_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            ent_mem[EW'(r_etotal)] <= ent_wdata;
        end
        ent_rd <= ent_mem[EW'(r_idx)];
    end

    // counts and walk status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_done_n   <= '0;
            r_etotal   <= '0;
            r_walk_err <= 1'b0;
        end else begin
            if (par_we) begin
                r_loaded <= r_loaded + CW'(1);
            end
            if (i_cmd.op == OP_CINIT) begin
                r_etotal   <= '0;
                r_walk_err <= 1'b0;
            end else if (ent_we) begin
                r_etotal <= r_etotal + ECW'(1);
            end
            if (i_cmd.op == OP_CHK && (den_bad || ent_full)) begin
                r_walk_err <= 1'b1;
            end
            // diagonal entries at or past this index read as zero
            if (i_cmd.op == OP_CDONE) begin
                r_done_n <= r_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req     <= i_req_type;
            r_sire_in <= i_sire_id;
            r_dam_in  <= i_dam_id;
            r_idx     <= i_read_index;
        end
        case (i_cmd.op)
            OP_CINIT: r_i <= '0;
            OP_PAR: begin
                r_s <= par_rd_s;
                r_d <= par_rd_d;
            end
            OP_US: r_us <= (r_s != '0) ? u_rd : 40'd0;
            OP_UD: r_ud <= (r_d != '0) ? u_rd : 40'd0;
            OP_DEN: begin
                // the first animal's pass ignores stale terms from an earlier run
                r_ui  <= (r_i == '0) ? 40'd0 : u_rd;
                r_den <= den_w;
            end
            OP_PAIR: r_j <= r_i + CW'(1);
            OP_JCHK: begin
                if (r_j >= r_loaded) begin
                    r_i <= r_i + CW'(1);
                end
            end
            OP_JPAR: begin
                r_js <= par_rd_s;
                r_jd <= par_rd_d;
            end
            OP_JVS: r_vs <= js_live ? v_rd : '0;
            OP_JVD: r_vd <= jd_live ? v_rd : '0;
            OP_JSUM: begin
                r_summ <= summ_n;
                r_uj   <= (r_i == '0) ? 40'd0 : u_rd;
            end
            OP_JMUL: r_prod <= (2*VW)'(r_summ) * (2*VW)'(r_summ);
            OP_JWR:  r_j <= r_j + CW'(1);
            OP_LOAD: begin
                r_row  <= ld_full ? 11'd0 : 11'(me);
                r_col  <= ld_full ? 11'd0 : 11'(me);
                r_coef <= '0;
                r_err  <= ld_full || !sire_ok || !dam_ok;
            end
            OP_RDOUT: begin
                if (r_req == REQ_RD_DIAG) begin
                    r_row  <= diag_ok ? 11'(XW'(r_idx) + XW'(1)) : 11'd0;
                    r_col  <= diag_ok ? 11'(XW'(r_idx) + XW'(1)) : 11'd0;
                    r_coef <= (diag_ok && diag_fresh) ? d_rd : 40'd0;
                    r_err  <= !diag_ok;
                end else begin
                    r_row  <= ent_ok ? 11'(XW'(ent_row_rd) + XW'(1)) : 11'd0;
                    r_col  <= ent_ok ? 11'(XW'(ent_col_rd) + XW'(1)) : 11'd0;
                    r_coef <= ent_ok ? ent_rd[39:0] : 40'd0;
                    r_err  <= !ent_ok;
                end
            end
            OP_CDONE: begin
                r_row  <= '0;
                r_col  <= '0;
                r_coef <= '0;
                r_err  <= r_walk_err;
            end
            default: ;
        endcase
    end

    assign o_row_index   = r_row;
    assign o_col_index   = r_col;
    assign o_coef_value  = r_coef;
    assign o_entry_count = 12'(r_etotal);
    assign o_error_flag  = r_err;

endmodule
`default_nettype wire
